// ----- design/cks_pkg.sv -----
package cks_pkg;

  // image limits
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int COORD_W = $clog2(MAX_DIM);

  // pixel and register widths
  localparam int PIXEL_W = 24;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = PIXEL_W / CHAN_W;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  // queue between classifier and run tracker
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  // result kinds
  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- design/cks_front.sv -----
module cks_front (
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [cks_pkg::PIXEL_W-1:0]   pixel,
  input  logic [cks_pkg::PIXEL_W-1:0]   key_color,
  input  logic [cks_pkg::PIXEL_W-1:0]   tolerance,
  input  cks_pkg::q_status_t            q_status,
  output logic                          push,
  output logic                          opaque
);

  logic [cks_pkg::NCHAN-1:0] chan_ok;

  // per byte window test, upper bound saturates
  always_comb begin
    logic [cks_pkg::CHAN_W-1:0] p;
    logic [cks_pkg::CHAN_W-1:0] lo;
    logic [cks_pkg::CHAN_W:0]   hi_sum;
    logic [cks_pkg::CHAN_W-1:0] hi;
    for (int c = 0; c < cks_pkg::NCHAN; c++) begin
      p      = pixel[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W];
      lo     = key_color[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W];
      hi_sum = {1'b0, lo} + {1'b0, tolerance[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W]};
      hi     = hi_sum[cks_pkg::CHAN_W] ? {cks_pkg::CHAN_W{1'b1}}
                                       : hi_sum[cks_pkg::CHAN_W-1:0];
      chan_ok[c] = (p >= lo) && (p <= hi);
    end
  end

  assign opaque      = &chan_ok;
  assign pixel_ready = !q_status.full;
  assign push        = pixel_valid && pixel_ready;

endmodule

// ----- design/cks_fifo.sv -----
module cks_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               push_data,
  input  logic               pop,
  output logic               head,
  output cks_pkg::q_status_t q_status
);

  logic [cks_pkg::QUEUE_DEPTH-1:0] mem;
  logic [cks_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [cks_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [cks_pkg::QUEUE_CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head           = mem[rd_ptr];
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == cks_pkg::QUEUE_CW'(cks_pkg::QUEUE_DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full && !pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_status.empty))
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cks_pkg::QUEUE_CW'(cks_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- design/cks_back.sv -----
module cks_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cks_pkg::DIM_W-1:0]    image_width,
  input  logic [cks_pkg::DIM_W-1:0]    image_height,
  input  cks_pkg::q_status_t           q_status,
  input  logic                         head,
  output logic                         pop,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         kind,
  output logic [cks_pkg::DIM_W-1:0]    left,
  output logic [cks_pkg::DIM_W-1:0]    top,
  output logic [cks_pkg::DIM_W-1:0]    right,
  output logic [cks_pkg::DIM_W-1:0]    bottom,
  output logic                         last
);

  localparam logic [cks_pkg::DIM_W-1:0] MAXD = cks_pkg::DIM_W'(cks_pkg::MAX_DIM);
  localparam logic [cks_pkg::DIM_W-1:0] ONE  = cks_pkg::DIM_W'(1);

  logic [cks_pkg::COORD_W-1:0] column, column_next;
  logic [cks_pkg::COORD_W-1:0] row, row_next;
  logic                        run_active, run_active_next;
  logic [cks_pkg::COORD_W-1:0] run_start, run_start_next;
  logic [cks_pkg::DIM_W-1:0]   box_left, box_left_next;
  logic [cks_pkg::DIM_W-1:0]   box_top, box_top_next;
  logic [cks_pkg::DIM_W-1:0]   box_right, box_right_next;
  logic [cks_pkg::DIM_W-1:0]   box_bottom, box_bottom_next;
  logic                        second, second_next;
  logic                        result_valid_next;
  logic                        load;
  logic                        kind_next, last_next;
  logic [cks_pkg::DIM_W-1:0]   left_next, top_next, right_next, bottom_next;

  logic [cks_pkg::DIM_W-1:0]   w_eff, h_eff, col_inc, row_inc;
  logic [cks_pkg::DIM_W-1:0]   span_left, span_right;
  logic [cks_pkg::DIM_W-1:0]   nb_left, nb_top, nb_right, nb_bottom;
  logic                        row_end, img_end, span_hit, split, busy, box_emit;

  always_comb begin
    if (image_width == '0)       w_eff = ONE;
    else if (image_width > MAXD) w_eff = MAXD;
    else                         w_eff = image_width;
    if (image_height == '0)       h_eff = ONE;
    else if (image_height > MAXD) h_eff = MAXD;
    else                          h_eff = image_height;
  end

  assign col_inc    = {1'b0, column} + ONE;
  assign row_inc    = {1'b0, row} + ONE;
  assign row_end    = (col_inc >= w_eff);
  assign img_end    = row_end && (row_inc >= h_eff);
  assign span_hit   = (head && row_end) || (!head && run_active);
  assign span_left  = run_active ? {1'b0, run_start} : {1'b0, column};
  assign span_right = head ? col_inc : {1'b0, column};
  assign split      = span_hit && img_end && !second;
  assign busy       = !q_status.empty && (!result_valid || result_ready);

  // box widened by the current span
  assign nb_left   = (span_left < box_left) ? span_left : box_left;
  assign nb_top    = ({1'b0, row} < box_top) ? {1'b0, row} : box_top;
  assign nb_right  = (span_right > box_right) ? span_right : box_right;
  assign nb_bottom = (row_inc > box_bottom) ? row_inc : box_bottom;

  always_comb begin
    column_next     = column;
    row_next        = row;
    run_active_next = run_active;
    run_start_next  = run_start;
    box_left_next   = box_left;
    box_top_next    = box_top;
    box_right_next  = box_right;
    box_bottom_next = box_bottom;
    second_next     = second;
    pop             = 1'b0;
    load            = 1'b0;
    box_emit        = 1'b0;
    kind_next       = cks_pkg::KIND_SPAN;
    last_next       = 1'b1;
    left_next       = span_left;
    top_next        = {1'b0, row};
    right_next      = span_right;
    bottom_next     = row_inc;

    if (busy) begin
      if (second || (img_end && !span_hit)) begin
        // box summary closes the image
        load            = 1'b1;
        box_emit        = 1'b1;
        pop             = 1'b1;
        kind_next       = cks_pkg::KIND_BOX;
        left_next       = box_left;
        top_next        = box_top;
        right_next      = box_right;
        bottom_next     = box_bottom;
        box_left_next   = MAXD;
        box_top_next    = MAXD;
        box_right_next  = '0;
        box_bottom_next = '0;
        column_next     = '0;
        row_next        = '0;
        run_active_next = 1'b0;
        second_next     = 1'b0;
      end else if (split) begin
        // span first, box follows next time the output frees up
        load            = 1'b1;
        last_next       = 1'b0;
        box_left_next   = nb_left;
        box_top_next    = nb_top;
        box_right_next  = nb_right;
        box_bottom_next = nb_bottom;
        run_active_next = 1'b0;
        second_next     = 1'b1;
      end else begin
        pop = 1'b1;
        if (head && !run_active) begin
          run_active_next = 1'b1;
          run_start_next  = column;
        end
        if (span_hit) begin
          load            = 1'b1;
          box_left_next   = nb_left;
          box_top_next    = nb_top;
          box_right_next  = nb_right;
          box_bottom_next = nb_bottom;
          run_active_next = 1'b0;
        end
        if (row_end) begin
          column_next     = '0;
          run_active_next = 1'b0;
          row_next        = row_inc[cks_pkg::COORD_W-1:0];
        end else begin
          column_next = col_inc[cks_pkg::COORD_W-1:0];
        end
      end
    end

    result_valid_next = load || (result_valid && !result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      run_active   <= 1'b0;
      run_start    <= '0;
      box_left     <= MAXD;
      box_top      <= MAXD;
      box_right    <= '0;
      box_bottom   <= '0;
      second       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      column       <= column_next;
      row          <= row_next;
      run_active   <= run_active_next;
      run_start    <= run_start_next;
      box_left     <= box_left_next;
      box_top      <= box_top_next;
      box_right    <= box_right_next;
      box_bottom   <= box_bottom_next;
      second       <= second_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind   <= kind_next;
      left   <= left_next;
      top    <= top_next;
      right  <= right_next;
      bottom <= bottom_next;
      last   <= last_next;
    end
  end

  a_second_holds_item: assert property (@(posedge clk) disable iff (rst)
    second |-> !q_status.empty)
    else $error("pending box without its pixel in the queue");
  a_box_cleared: assert property (@(posedge clk) disable iff (rst)
    box_emit |=> (box_left == MAXD && box_top == MAXD && box_right == '0))
    else $error("box not cleared after summary");
  a_box_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == cks_pkg::KIND_BOX) |-> last)
    else $error("box summary not marked last");
  a_split_then_box: assert property (@(posedge clk) disable iff (rst)
    (busy && split) |=> second)
    else $error("span of closing pixel not followed by box");

endmodule

// ----- design/color_key_span_extractor_top.sv -----
// channel   | valid / ready                | payload
// ----------+------------------------------+----------------------------------------
// pixel in  | pixel_valid / pixel_ready    | pixel
// result out| result_valid / result_ready  | kind, left, top, right, bottom, last
// config    | cfg_write (no wait)          | cfg_index, cfg_data
//
// one pixel per cycle while pixel_ready is high; its results pass the flag queue, then the output register
// a pixel that closes both a run and the image loads the output register twice: span, then box
// rst is synchronous: clears the queue, run tracker, bounding box and registers
// a 4-entry queue of opaque flags parts the classifier from the run tracker
// result stalls back up into the queue; pixel_ready drops only when it is full
module color_key_span_extractor_top (
  input  logic                          clk,
  input  logic                          rst,
  // pixel stream
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [cks_pkg::PIXEL_W-1:0]   pixel,
  // result stream
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          kind,
  output logic [cks_pkg::DIM_W-1:0]     left,
  output logic [cks_pkg::DIM_W-1:0]     top,
  output logic [cks_pkg::DIM_W-1:0]     right,
  output logic [cks_pkg::DIM_W-1:0]     bottom,
  output logic                          last,
  // register writes
  input  logic                          cfg_write,
  input  logic [cks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cks_pkg::CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [cks_pkg::PIXEL_W-1:0] key_color;
  logic [cks_pkg::PIXEL_W-1:0] tolerance;
  logic [cks_pkg::DIM_W-1:0]   image_width;
  logic [cks_pkg::DIM_W-1:0]   image_height;

  // queue plumbing
  cks_pkg::q_status_t q_status;
  logic               push;
  logic               opaque;
  logic               pop;
  logic               head;

  // register file; the user must write it only while the stream is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      key_color    <= '0;
      tolerance    <= '0;
      image_width  <= cks_pkg::DIM_W'(1);
      image_height <= cks_pkg::DIM_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        cks_pkg::CFG_KEY_COLOR:    key_color    <= cfg_data[cks_pkg::PIXEL_W-1:0];
        cks_pkg::CFG_TOLERANCE:    tolerance    <= cfg_data[cks_pkg::PIXEL_W-1:0];
        cks_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[cks_pkg::DIM_W-1:0];
        cks_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[cks_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // classifier: byte window compare on the incoming pixel
  cks_front u_front (
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .key_color   (key_color),
    .tolerance   (tolerance),
    .q_status    (q_status),
    .push        (push),
    .opaque      (opaque)
  );

  // opaque flags waiting for the run tracker
  cks_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (opaque),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // run tracker: column/row counting, spans, bounding box, output register
  cks_back u_back (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .left         (left),
    .top          (top),
    .right        (right),
    .bottom       (bottom),
    .last         (last)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // one expected or observed result transaction
  typedef struct packed {
    logic                      kind;
    logic [cks_pkg::DIM_W-1:0] left;
    logic [cks_pkg::DIM_W-1:0] top;
    logic [cks_pkg::DIM_W-1:0] right;
    logic [cks_pkg::DIM_W-1:0] bottom;
    logic                      last;
  } region_t;

  // watchdog bound on the whole run
  localparam int CYCLE_LIMIT     = 500000;
  // queue of 4 opaque flags plus the output register, with margin
  localparam int SETTLE_CYCLES   = 32;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 1250;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          pixel_valid  = 1'b0;
  logic                          pixel_ready;
  logic [cks_pkg::PIXEL_W-1:0]   pixel        = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic                          kind;
  logic [cks_pkg::DIM_W-1:0]     left;
  logic [cks_pkg::DIM_W-1:0]     top;
  logic [cks_pkg::DIM_W-1:0]     right;
  logic [cks_pkg::DIM_W-1:0]     bottom;
  logic                          last;
  logic                          cfg_write    = 1'b0;
  logic [cks_pkg::CFG_IDX_W-1:0] cfg_index    = cks_pkg::CFG_KEY_COLOR;
  logic [cks_pkg::CFG_W-1:0]     cfg_data     = '0;

  color_key_span_extractor_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .left         (left),
    .top          (top),
    .right        (right),
    .bottom       (bottom),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pixels waiting to be offered, and results the block still owes us
  logic [cks_pkg::PIXEL_W-1:0] pending_pixels[$];
  region_t                     expected_regions[$];

  // idling knobs, set per phase by the stimulus process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off: stimulus bumps the request count, monitor serves it
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;

  int errors         = 0;
  int cycle_count    = 0;

  // shadow copy of the register file
  logic [23:0] key_reg    = '0;
  logic [23:0] tol_reg    = '0;
  logic [12:0] width_reg  = 13'd1;
  logic [12:0] height_reg = 13'd1;

  // shadow copy of the scan position, open run and bounding box
  int unsigned col_pos   = 0;
  int unsigned row_pos   = 0;
  bit          in_run    = 1'b0;
  int unsigned run_col   = 0;
  int unsigned bb_left   = cks_pkg::MAX_DIM;
  int unsigned bb_top    = cks_pkg::MAX_DIM;
  int unsigned bb_right  = 0;
  int unsigned bb_bottom = 0;

  // zero reads as one, anything past the limit as the limit
  function automatic int unsigned clamp_dim(logic [12:0] v);
    if (v == 0) return 1;
    if (v > cks_pkg::MAX_DIM) return cks_pkg::MAX_DIM;
    return {19'b0, v};
  endfunction

  // every byte must sit in [key, key + tol], upper bound saturating at 0xff
  function automatic bit pixel_opaque(logic [cks_pkg::PIXEL_W-1:0] px);
    int lo;
    int hi;
    for (int c = 0; c < cks_pkg::NCHAN; c++) begin
      lo = int'(key_reg[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W]);
      hi = lo + int'(tol_reg[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W]);
      if (hi > 255) hi = 255;
      if (px[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W] < lo ||
          px[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W] > hi) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the shadow scan by one pixel and queue the spans / box it closes
  task automatic predict_regions(input logic [cks_pkg::PIXEL_W-1:0] px);
    int unsigned w;
    int unsigned h;
    bit          op;
    bit          row_end;
    bit          have_span;
    bit          have_box;
    int unsigned span_end;
    region_t     span;
    region_t     box;
    w         = clamp_dim(width_reg);
    h         = clamp_dim(height_reg);
    op        = pixel_opaque(px);
    row_end   = (col_pos + 1 >= w);
    have_span = 1'b0;
    have_box  = 1'b0;
    span_end  = 0;
    if (op) begin
      if (!in_run) begin
        in_run  = 1'b1;
        run_col = col_pos;
      end
      // row ends on an opaque pixel: the span closes past it
      if (row_end) begin
        have_span = 1'b1;
        span_end  = col_pos + 1;
      end
    end else if (in_run) begin
      have_span = 1'b1;
      span_end  = col_pos;
    end
    if (have_span) begin
      span.kind   = cks_pkg::KIND_SPAN;
      span.left   = cks_pkg::DIM_W'(run_col);
      span.top    = cks_pkg::DIM_W'(row_pos);
      span.right  = cks_pkg::DIM_W'(span_end);
      span.bottom = cks_pkg::DIM_W'(row_pos + 1);
      span.last   = 1'b0;
      if (run_col < bb_left) bb_left = run_col;
      if (row_pos < bb_top) bb_top = row_pos;
      if (span_end > bb_right) bb_right = span_end;
      if (row_pos + 1 > bb_bottom) bb_bottom = row_pos + 1;
      in_run = 1'b0;
    end
    if (row_end) begin
      col_pos = 0;
      in_run  = 1'b0;
      if (row_pos + 1 >= h) begin
        // end of image: report the box, empty sentinel included, then clear it
        have_box   = 1'b1;
        box.kind   = cks_pkg::KIND_BOX;
        box.left   = cks_pkg::DIM_W'(bb_left);
        box.top    = cks_pkg::DIM_W'(bb_top);
        box.right  = cks_pkg::DIM_W'(bb_right);
        box.bottom = cks_pkg::DIM_W'(bb_bottom);
        box.last   = 1'b1;
        bb_left    = cks_pkg::MAX_DIM;
        bb_top     = cks_pkg::MAX_DIM;
        bb_right   = 0;
        bb_bottom  = 0;
        row_pos    = 0;
      end else begin
        row_pos = (row_pos + 1) & 12'hfff;
      end
    end else begin
      col_pos = (col_pos + 1) & 12'hfff;
    end
    // span before box; only the final one carries last
    if (have_span) begin
      span.last = !have_box;
      expected_regions.push_back(span);
    end
    if (have_box) expected_regions.push_back(box);
  endtask

  task automatic compare_field(input string name, input logic [cks_pkg::DIM_W-1:0] want,
                               input logic [cks_pkg::DIM_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // driver: offers pending pixels, predicting each one the cycle it is taken
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) predict_regions(pixel);
      // payload only moves once the current transaction is gone
      if (!pixel_valid || pixel_ready) begin
        if (pending_pixels.size() > 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          pixel_valid <= 1'b1;
          pixel       <= pending_pixels.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every accepted result, and throttles result_ready
  always @(posedge clk) begin
    region_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_regions.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %s%0d l=%0d t=%0d",
                   $time, "kind=", kind, left, top);
          $display("%0t:   r=%0d b=%0d last=%0d", $time, right, bottom, last);
        end else begin
          want = expected_regions.pop_front();
          compare_field("kind", cks_pkg::DIM_W'(want.kind), cks_pkg::DIM_W'(kind));
          compare_field("left", want.left, left);
          compare_field("top", want.top, top);
          compare_field("right", want.right, right);
          compare_field("bottom", want.bottom, bottom);
          compare_field("last", cks_pkg::DIM_W'(want.last), cks_pkg::DIM_W'(last));
        end
      end
      // a long hold-off lets the flag queue fill and stall pixel_ready
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_OFF_CYCLES;
        result_ready <= 1'b0;
      end else begin
        result_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, expected_regions.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // register write; only ever called while the block is idle
  task automatic write_reg(input logic [cks_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[cks_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      cks_pkg::CFG_KEY_COLOR:    key_reg    = value[23:0];
      cks_pkg::CFG_TOLERANCE:    tol_reg    = value[23:0];
      cks_pkg::CFG_IMAGE_WIDTH:  width_reg  = value[12:0];
      cks_pkg::CFG_IMAGE_HEIGHT: height_reg = value[12:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned key, input int unsigned tol,
                           input int unsigned w, input int unsigned h);
    write_reg(cks_pkg::CFG_KEY_COLOR, key);
    write_reg(cks_pkg::CFG_TOLERANCE, tol);
    write_reg(cks_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(cks_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // wait until every pixel is in and every result is out, then let the
  // flag queue drain pixels that close nothing
  task automatic settle();
    while (pending_pixels.size() != 0 || pixel_valid || expected_regions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixels(input logic [cks_pkg::PIXEL_W-1:0] list[$]);
    @(negedge clk);
    foreach (list[i]) pending_pixels.push_back(list[i]);
  endtask

  // opaque: each byte drawn inside its window; otherwise fully random
  function automatic logic [cks_pkg::PIXEL_W-1:0] make_pixel(input bit want_opaque);
    logic [cks_pkg::PIXEL_W-1:0] px;
    int lo;
    int hi;
    px = cks_pkg::PIXEL_W'($urandom);
    if (want_opaque) begin
      for (int c = 0; c < cks_pkg::NCHAN; c++) begin
        lo = int'(key_reg[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W]);
        hi = lo + int'(tol_reg[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W]);
        if (hi > 255) hi = 255;
        px[c*cks_pkg::CHAN_W +: cks_pkg::CHAN_W] = cks_pkg::CHAN_W'($urandom_range(hi, lo));
      end
    end
    return px;
  endfunction

  initial begin
    int          phase;
    int          count;
    int          random_items;
    int unsigned key;
    int unsigned tol;
    int unsigned w;
    int unsigned h;
    bit          opaque_run;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed part, no idling ---

    // reset settings: 1x1 image, only black is opaque
    // black gives span and box in one step, the others an empty box
    queue_pixels('{24'h000000, 24'hffffff, 24'h000001});
    settle();

    // key and tolerance saturate at 0xff: only white is opaque
    // row 0 has a run cut by a transparent pixel and one cut by the row end,
    // row 1 closes a run on the image's last pixel
    configure(24'hffffff, 24'hffffff, 4, 2);
    queue_pixels('{24'hffffff, 24'hffffff, 24'hfffeff, 24'hffffff,
                   24'h7fffff, 24'hffffff, 24'hffffff, 24'hffff00});
    settle();

    // zero width reads as one, oversize height as the limit
    configure(24'h000000, 24'h7f7f7f, 0, 8191);
    queue_pixels('{24'h7f7f7f, 24'h807f7f, 24'h000000, 24'h7f7f80});
    settle();
    // height shrunk below the current row: the next pixel ends the image
    write_reg(cks_pkg::CFG_IMAGE_HEIGHT, 2);
    queue_pixels('{24'h7f0000});
    settle();

    // oversize width, then shrunk under the current column mid-row
    configure(24'h102030, 24'h0f0f0f, 8191, 1);
    queue_pixels('{24'h102030, 24'h1f2f3f, 24'h0f2030, 24'h1a2a3a,
                   24'h10203f, 24'h1f2030});
    settle();
    write_reg(cks_pkg::CFG_IMAGE_WIDTH, 2);
    queue_pixels('{24'h202030});
    settle();

    // --- random part: small images, settings and idling vary by phase ---
    random_items = 0;
    phase        = 0;
    opaque_run   = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (phase % 6)
        0: begin key = $urandom;   tol = $urandom;                end
        1: begin key = 24'h000000; tol = 24'h000000;              end
        2: begin key = 24'hffffff; tol = 24'hffffff;              end
        3: begin key = 24'h000000; tol = 24'hffffff;              end
        4: begin key = $urandom;   tol = $urandom & 24'h1f1f1f;   end
        default: begin key = $urandom; tol = $urandom & 24'h0f3f7f; end
      endcase
      // mostly small frames; now and then a zero or a full-width row
      case ($urandom_range(11))
        0:       w = 0;
        1:       w = 1;
        2:       w = cks_pkg::MAX_DIM;
        default: w = $urandom_range(12, 2);
      endcase
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
      configure(key, tol, w, h);
      // pixel count is not a multiple of the frame, so the next phase
      // rewrites the registers mid-image
      count = $urandom_range(110, 50);
      if (phase % 8 == 4) hold_requests++;
      @(negedge clk);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(2) == 0) opaque_run = !opaque_run;
        pending_pixels.push_back(make_pixel(opaque_run));
      end
      random_items += count;
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
